/* src/dfs_pkg.sv */
// Shared types and constants for the delimited field selector.
// Used by dfs_ctrl, dfs_datapath and delimited_field_selector.
package dfs_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int TAIL_W     = 16;
	localparam int BYTE_W     = 8;
	localparam int CMP_W      = 33;

	localparam int MAP_POSITIONS_DEF = 64;
	localparam int HOLD_DEPTH_DEF    = 32;
	localparam int POSITION_BITS_DEF = 16;

	localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;
	localparam logic [BYTE_W-1:0] TAB_BYTE     = 8'h09;

	// output delimiter kinds; any other code behaves as the default kind
	localparam logic [1:0] OD_BYTE = 2'd1;
	localparam logic [1:0] OD_NONE = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIELD_MODE = 3'd0,
		REG_DELIMITER  = 3'd1,
		REG_COMPLEMENT = 3'd2,
		REG_ONLY_DELIM = 3'd3,
		REG_OD_KIND    = 3'd4,
		REG_OD_BYTE    = 3'd5,
		REG_SELECT_MAP = 3'd6,
		REG_TAIL_START = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		SRC_FLUSH,
		SRC_A,
		SRC_B
	} src_t;

	typedef struct packed {
		logic accept;
		logic push;
		src_t src;
		logic last;
	} dfs_cmd_t;

	typedef struct packed {
		logic plan_flush;
		logic plan_a;
		logic flush_end;
		logic a_v;
		logic b_v;
		logic out_free;
	} dfs_stat_t;

endpackage

/* src/dfs_ctrl.sv */
// Controller state machine of the delimited field selector.
// Sequences accept, hold-buffer flush and result slots; uses dfs_pkg.
module dfs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  dfs_pkg::dfs_stat_t stat,
	output dfs_pkg::dfs_cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_FLUSH,
		S_EMIT_A,
		S_EMIT_B
	} state_t;

	state_t state_q;

	always_comb begin
		in_ready   = (state_q == S_IDLE);
		cmd.accept = in_valid & in_ready;
		cmd.push   = 1'b0;
		cmd.src    = dfs_pkg::SRC_A;
		cmd.last   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
			end
			S_FLUSH: begin
				cmd.push = stat.out_free;
				cmd.src  = dfs_pkg::SRC_FLUSH;
				cmd.last = stat.flush_end & ~stat.a_v;
			end
			S_EMIT_A: begin
				cmd.push = stat.out_free;
				cmd.src  = dfs_pkg::SRC_A;
				cmd.last = ~stat.b_v;
			end
			S_EMIT_B: begin
				cmd.push = stat.out_free;
				cmd.src  = dfs_pkg::SRC_B;
				cmd.last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.accept) begin
						if (stat.plan_flush)
							state_q <= S_FLUSH;
						else if (stat.plan_a)
							state_q <= S_EMIT_A;
					end
				end
				S_FLUSH: begin
					if (cmd.push && stat.flush_end)
						state_q <= stat.a_v ? S_EMIT_A : S_IDLE;
				end
				S_EMIT_A: begin
					if (cmd.push)
						state_q <= stat.b_v ? S_EMIT_B : S_IDLE;
				end
				S_EMIT_B: begin
					if (cmd.push)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* src/dfs_datapath.sv */
// Datapath of the delimited field selector: configuration registers, line
// state, hold buffer, selection logic and output register. Uses dfs_pkg.
module dfs_datapath #(
	parameter int MAP_POSITIONS = dfs_pkg::MAP_POSITIONS_DEF,
	parameter int HOLD_DEPTH    = dfs_pkg::HOLD_DEPTH_DEF,
	parameter int POSITION_BITS = dfs_pkg::POSITION_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [dfs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dfs_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [dfs_pkg::BYTE_W-1:0]      in_byte,
	input  logic                            line_end,
	input  dfs_pkg::dfs_cmd_t               cmd,
	output dfs_pkg::dfs_stat_t              stat,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [dfs_pkg::BYTE_W-1:0]      out_byte,
	output logic                            out_last,
	output logic                            out_done,
	output logic                            out_trunc
);

	localparam int HC_W      = $clog2(HOLD_DEPTH + 1);
	localparam int HIDX_W    = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
	localparam int MAP_IDX_W = $clog2(MAP_POSITIONS);
	localparam int PW        = POSITION_BITS + 1;
	localparam int CMP_W     = dfs_pkg::CMP_W;
	localparam int BW        = dfs_pkg::BYTE_W;

	// configuration
	logic                          field_mode_q;
	logic [BW-1:0]                 delim_q;
	logic                          complement_q;
	logic                          only_delim_q;
	logic [1:0]                    od_kind_q;
	logic [BW-1:0]                 od_byte_q;
	logic [MAP_POSITIONS-1:0]      select_map_q;
	logic [dfs_pkg::TAIL_W-1:0]    tail_start_q;

	// line state
	logic [POSITION_BITS-1:0]      pc_q;
	logic                          any_q;
	logic                          dseen_q;
	logic [HC_W-1:0]               hcnt_q;
	logic                          hovf_q;

	// result plan of the current transaction
	logic                          a_v_q;
	logic [BW-1:0]                 a_byte_q;
	logic                          a_nl_q;
	logic                          a_tr_q;
	logic                          b_v_q;
	logic [BW-1:0]                 b_byte_q;
	logic [HC_W-1:0]               fl_n_q;
	logic [HC_W-1:0]               ptr_q;

	logic [BW-1:0]                 hold_mem [HOLD_DEPTH];
	logic [BW-1:0]                 rd_q;
	logic [HIDX_W-1:0]             rd_addr;

	logic                          out_valid_q;
	logic [BW-1:0]                 out_byte_q;
	logic                          out_last_q;
	logic                          out_done_q;
	logic                          out_trunc_q;

	logic                          fmode, od, has_od;
	logic [BW-1:0]                 od_b;
	logic [PW-1:0]                 pos, pos_nx;
	logic [POSITION_BITS-1:0]      pc_bump;
	logic                          sel_cur, sel_nx;
	logic                          pl_flush, pl_a, pl_a_nl, pl_a_tr, pl_b;
	logic [BW-1:0]                 pl_a_byte;
	logic [POSITION_BITS-1:0]      pc_d;
	logic                          any_d, dseen_d, hovf_d, hold_we;
	logic [HC_W-1:0]               hcnt_d;
	logic [HC_W-1:0]               ptr_inc;

	function automatic logic sel_hit(input logic [PW-1:0] p);
		logic          hit;
		logic [PW-1:0] pm1;
		pm1 = p - 1'b1;
		hit = 1'b0;
		if (p != '0 && CMP_W'(p) <= CMP_W'(MAP_POSITIONS))
			hit = select_map_q[pm1[MAP_IDX_W-1:0]];
		if (tail_start_q != '0 && CMP_W'(p) >= CMP_W'(tail_start_q))
			hit = 1'b1;
		return hit ^ complement_q;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_mode_q <= 1'b1;
			delim_q      <= dfs_pkg::TAB_BYTE;
			complement_q <= 1'b0;
			only_delim_q <= 1'b0;
			od_kind_q    <= '0;
			od_byte_q    <= dfs_pkg::TAB_BYTE;
			select_map_q <= '0;
			tail_start_q <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				dfs_pkg::REG_FIELD_MODE: field_mode_q <= cfg_data[0];
				dfs_pkg::REG_DELIMITER:  delim_q      <= cfg_data[BW-1:0];
				dfs_pkg::REG_COMPLEMENT: complement_q <= cfg_data[0];
				dfs_pkg::REG_ONLY_DELIM: only_delim_q <= cfg_data[0];
				dfs_pkg::REG_OD_KIND:    od_kind_q    <= cfg_data[1:0];
				dfs_pkg::REG_OD_BYTE:    od_byte_q    <= cfg_data[BW-1:0];
				dfs_pkg::REG_SELECT_MAP: select_map_q <= cfg_data[MAP_POSITIONS-1:0];
				dfs_pkg::REG_TAIL_START: tail_start_q <= cfg_data[dfs_pkg::TAIL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		fmode = field_mode_q;
		od    = fmode & only_delim_q;
		case (od_kind_q)
			dfs_pkg::OD_BYTE: begin
				has_od = 1'b1;
				od_b   = od_byte_q;
			end
			dfs_pkg::OD_NONE: begin
				has_od = 1'b0;
				od_b   = od_byte_q;
			end
			default: begin
				has_od = fmode;
				od_b   = delim_q;
			end
		endcase

		pos     = {1'b0, pc_q} + 1'b1;
		pc_bump = (&pc_q) ? pc_q : pc_q + 1'b1;
		pos_nx  = {1'b0, pc_bump} + 1'b1;
		sel_cur = sel_hit(pos);
		sel_nx  = sel_hit(pos_nx);

		pl_flush  = 1'b0;
		pl_a      = 1'b0;
		pl_a_byte = in_byte;
		pl_a_nl   = 1'b0;
		pl_a_tr   = 1'b0;
		pl_b      = 1'b0;
		pc_d      = pc_q;
		any_d     = any_q;
		dseen_d   = dseen_q;
		hcnt_d    = hcnt_q;
		hovf_d    = hovf_q;
		hold_we   = 1'b0;

		if (line_end) begin
			pl_a      = ~(od & ~dseen_q);
			pl_a_byte = dfs_pkg::NEWLINE_BYTE;
			pl_a_nl   = 1'b1;
			pl_a_tr   = hovf_q;
			pc_d      = '0;
			any_d     = 1'b0;
			dseen_d   = 1'b0;
			hcnt_d    = '0;
			hovf_d    = 1'b0;
		end else if (!fmode) begin
			pc_d = pc_bump;
			if (sel_cur) begin
				any_d = 1'b1;
				pl_a  = 1'b1;
				if (any_q && has_od) begin
					pl_a_byte = od_b;
					pl_b      = 1'b1;
				end
			end
		end else if (in_byte == delim_q) begin
			if (!dseen_q) begin
				pl_flush = (hcnt_q != '0);
				hcnt_d   = '0;
			end
			dseen_d = 1'b1;
			any_d   = any_q | sel_cur;
			pc_d    = pc_bump;
			if (sel_nx && (any_q || sel_cur) && has_od) begin
				pl_a      = 1'b1;
				pl_a_byte = od_b;
			end
		end else if (sel_cur) begin
			if (od && !dseen_q) begin
				if (hcnt_q < HC_W'(HOLD_DEPTH)) begin
					hold_we = 1'b1;
					hcnt_d  = hcnt_q + 1'b1;
				end else begin
					hovf_d = 1'b1;
				end
			end else begin
				pl_a = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= '0;
			any_q   <= 1'b0;
			dseen_q <= 1'b0;
			hcnt_q  <= '0;
			hovf_q  <= 1'b0;
			a_v_q   <= 1'b0;
			b_v_q   <= 1'b0;
			fl_n_q  <= '0;
			ptr_q   <= '0;
		end else if (cmd.accept) begin
			pc_q    <= pc_d;
			any_q   <= any_d;
			dseen_q <= dseen_d;
			hcnt_q  <= hcnt_d;
			hovf_q  <= hovf_d;
			a_v_q   <= pl_a;
			b_v_q   <= pl_b;
			fl_n_q  <= hcnt_q;
			ptr_q   <= '0;
		end else if (cmd.push && cmd.src == dfs_pkg::SRC_FLUSH) begin
			ptr_q <= ptr_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			a_byte_q <= pl_a_byte;
			a_nl_q   <= pl_a_nl;
			a_tr_q   <= pl_a_tr;
			b_byte_q <= in_byte;
		end
	end

	assign ptr_inc = ptr_q + 1'b1;

	always_comb begin
		if (cmd.accept)
			rd_addr = '0;
		else if (cmd.push && cmd.src == dfs_pkg::SRC_FLUSH)
			rd_addr = (ptr_inc < HC_W'(HOLD_DEPTH)) ? ptr_inc[HIDX_W-1:0] : '0;
		else
			rd_addr = (ptr_q < HC_W'(HOLD_DEPTH)) ? ptr_q[HIDX_W-1:0] : '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && hold_we)
			hold_mem[hcnt_q[HIDX_W-1:0]] <= in_byte;
		rd_q <= hold_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_last_q <= cmd.last;
			case (cmd.src)
				dfs_pkg::SRC_FLUSH: begin
					out_byte_q  <= rd_q;
					out_done_q  <= 1'b0;
					out_trunc_q <= 1'b0;
				end
				dfs_pkg::SRC_A: begin
					out_byte_q  <= a_byte_q;
					out_done_q  <= a_nl_q;
					out_trunc_q <= a_tr_q;
				end
				default: begin
					out_byte_q  <= b_byte_q;
					out_done_q  <= 1'b0;
					out_trunc_q <= 1'b0;
				end
			endcase
		end
	end

	assign stat.plan_flush = pl_flush;
	assign stat.plan_a     = pl_a;
	assign stat.flush_end  = (ptr_inc == fl_n_q);
	assign stat.a_v        = a_v_q;
	assign stat.b_v        = b_v_q;
	assign stat.out_free   = ~out_valid_q | out_ready;

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;
	assign out_done  = out_done_q;
	assign out_trunc = out_trunc_q;

endmodule

/* src/delimited_field_selector.sv */
// Top level of the delimited field selector (cut-style byte/field selection).
// Instantiates dfs_ctrl and dfs_datapath; uses dfs_pkg.
//
// Each input transaction is one line byte or a line-end mark; its n results
// (n is 0 to HOLD_DEPTH + 1) leave through a single output register at one
// per cycle while the master accepts, and the next input is taken after the
// last is pushed. A flush of held field-one bytes reads the hold buffer
// through its one registered read port, one byte a cycle while the output is
// free. The output register lets the next input be taken while the previous
// one's last result still waits on the master side. The hold buffer needs no
// clearing after reset. Configuration writes are meant for idle periods.
module delimited_field_selector #(
	parameter int MAP_POSITIONS = dfs_pkg::MAP_POSITIONS_DEF,
	parameter int HOLD_DEPTH    = dfs_pkg::HOLD_DEPTH_DEF,
	parameter int POSITION_BITS = dfs_pkg::POSITION_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,  // [7:0] in_byte
	input  logic                           s_axis_tuser,  // [0] line_end
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [7:0]                     m_axis_tdata,  // [7:0] out_byte
	output logic                           m_axis_tlast,
	output logic [1:0]                     m_axis_tuser,  // [0] line_done, [1] truncated
	input  logic                           cfg_wen,
	input  logic [dfs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dfs_pkg::CFG_DATA_W-1:0] cfg_data
);

	dfs_pkg::dfs_cmd_t  cmd;
	dfs_pkg::dfs_stat_t stat;
	logic               done, trunc;

	dfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dfs_datapath #(
		.MAP_POSITIONS (MAP_POSITIONS),
		.HOLD_DEPTH    (HOLD_DEPTH),
		.POSITION_BITS (POSITION_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_byte   (s_axis_tdata),
		.line_end  (s_axis_tuser),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_done  (done),
		.out_trunc (trunc)
	);

	assign m_axis_tuser = {trunc, done};

endmodule
